// ----- hw/rtl/lsq_pkg.sv -----
// Package for the least-squares line fit: field widths, command and status
// structs between controller and datapath, and the state and code enums.
// No dependencies.
`default_nettype none

package lsq_pkg;

    localparam int MAX_SAMPLES      = 4096;
    localparam int SAMPLE_WIDTH     = 16;
    localparam int SAMPLE_FRAC_BITS = 8;

    // Count and running sums.
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SX_W  = SAMPLE_WIDTH + CNT_W;
    localparam int SXX_W = 2 * SAMPLE_WIDTH + CNT_W - 1;
    localparam int SXY_W = 2 * SAMPLE_WIDTH + CNT_W;

    // Products of sums, and the shift-add multiplier.
    localparam int ACC_W  = SX_W + SXY_W;
    localparam int MCNT_W = $clog2(SX_W + 1);

    // Quotients are Q16.16.
    localparam int OUT_W        = 32;
    localparam int SLOPE_SHIFT  = 16;
    localparam int ICPT_SHIFT   = 16 - SAMPLE_FRAC_BITS;
    localparam int NUM_W        = ACC_W + SLOPE_SHIFT;
    localparam int DCNT_W       = $clog2(NUM_W + 1);

    // Order of products: each even one starts a term, each odd one subtracts.
    typedef enum logic [2:0] {
        MUL_N_SXX  = 3'd0,
        MUL_SX_SX  = 3'd1,
        MUL_N_SXY  = 3'd2,
        MUL_SX_SY  = 3'd3,
        MUL_SXX_SY = 3'd4,
        MUL_SX_SXY = 3'd5
    } mul_sel_t;

    typedef enum logic {
        DIV_SLOPE = 1'b0,
        DIV_ICPT  = 1'b1
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_MUL_WAIT,
        ST_FIT,
        ST_DIV_S,
        ST_DIV_I,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     sample_en;
        logic     clear;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     store_en;
        logic     fit_begin;
        logic     div_start;
        div_sel_t div_sel;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic den_zero;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lsq_datapath.sv -----
// Datapath of the line fit: sample sums, shift-add multiplier, restoring
// divider and result registers. Depends on lsq_pkg.
`default_nettype none

module lsq_datapath
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic signed [lsq_pkg::SAMPLE_WIDTH-1:0]   x,
    input  wire logic signed [lsq_pkg::SAMPLE_WIDTH-1:0]   y,
    input  wire lsq_pkg::cmd_t                             cmd,
    output lsq_pkg::status_t                               status,
    output logic signed [lsq_pkg::OUT_W-1:0]               slope,
    output logic signed [lsq_pkg::OUT_W-1:0]               intercept,
    output logic                                           degenerate,
    output logic                                           saturated,
    output logic                                           overflowed
);

    localparam int SW    = lsq_pkg::SAMPLE_WIDTH;
    localparam int CNT_W = lsq_pkg::CNT_W;
    localparam int SX_W  = lsq_pkg::SX_W;
    localparam int SXX_W = lsq_pkg::SXX_W;
    localparam int SXY_W = lsq_pkg::SXY_W;
    localparam int ACC_W = lsq_pkg::ACC_W;
    localparam int NUM_W = lsq_pkg::NUM_W;
    localparam int OUT_W = lsq_pkg::OUT_W;

    // Sums.
    logic        [CNT_W-1:0] cnt_reg;
    logic signed [SX_W-1:0]  sx_reg;
    logic signed [SX_W-1:0]  sy_reg;
    logic signed [SXX_W-1:0] sxx_reg;
    logic signed [SXY_W-1:0] sxy_reg;
    logic                    drop_reg;

    logic signed [2*SW-1:0]  xx;
    logic signed [2*SW-1:0]  xy;

    assign xx = x * x;
    assign xy = x * y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxx_reg  <= '0;
            sxy_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            cnt_reg  <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxx_reg  <= '0;
            sxy_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (cmd.sample_en)
        begin
            if (cnt_reg == CNT_W'(lsq_pkg::MAX_SAMPLES))
            begin
                drop_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sx_reg  <= sx_reg + {{(SX_W-SW){x[SW-1]}}, x};
                sy_reg  <= sy_reg + {{(SX_W-SW){y[SW-1]}}, y};
                sxx_reg <= sxx_reg + {{(SXX_W-2*SW){xx[2*SW-1]}}, xx};
                sxy_reg <= sxy_reg + {{(SXY_W-2*SW){xy[2*SW-1]}}, xy};
            end
        end
    end

    // Operand selection. The narrow operand always goes to b.
    logic signed [SXY_W-1:0] op_a;
    logic signed [SX_W-1:0]  op_b;
    logic signed [SXY_W-1:0] sxx_ext;
    logic signed [SXY_W-1:0] sx_ext_a;
    logic signed [SX_W-1:0]  n_ext;
    logic        [SXY_W-1:0] a_mag;
    logic        [SX_W-1:0]  b_mag;
    logic                    mul_sub;

    assign sxx_ext  = {{(SXY_W-SXX_W){sxx_reg[SXX_W-1]}}, sxx_reg};
    assign sx_ext_a = {{(SXY_W-SX_W){sx_reg[SX_W-1]}}, sx_reg};
    assign n_ext    = {{(SX_W-CNT_W){1'b0}}, cnt_reg};

    always_comb
    begin
        case (cmd.mul_sel)
            lsq_pkg::MUL_N_SXX:  begin op_a = sxx_ext;  op_b = n_ext;  end
            lsq_pkg::MUL_SX_SX:  begin op_a = sx_ext_a; op_b = sx_reg; end
            lsq_pkg::MUL_N_SXY:  begin op_a = sxy_reg;  op_b = n_ext;  end
            lsq_pkg::MUL_SX_SY:  begin op_a = sx_ext_a; op_b = sy_reg; end
            lsq_pkg::MUL_SXX_SY: begin op_a = sxx_ext;  op_b = sy_reg; end
            lsq_pkg::MUL_SX_SXY: begin op_a = sxy_reg;  op_b = sx_reg; end
            default:             begin op_a = '0;       op_b = '0;     end
        endcase
    end

    assign a_mag   = op_a[SXY_W-1] ? SXY_W'(-op_a) : op_a;
    assign b_mag   = op_b[SX_W-1] ? SX_W'(-op_b) : op_b;
    assign mul_sub = cmd.mul_sel[0];

    // Shift-add multiplier, one bit of b per cycle, summing into acc_reg.
    logic        [ACC_W-1:0]           a_reg;
    logic        [SX_W-1:0]            b_reg;
    logic                              neg_reg;
    logic        [lsq_pkg::MCNT_W-1:0] mcnt_reg;
    logic                              mbusy_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [ACC_W-1:0]           den_reg;
    logic signed [ACC_W-1:0]           ns_reg;
    logic signed [ACC_W-1:0]           ni_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
        end
        else if (cmd.mul_start)
        begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= lsq_pkg::MCNT_W'(SX_W);
        end
        else if (mbusy_reg)
        begin
            mcnt_reg <= mcnt_reg - 1'b1;
            if (mcnt_reg == lsq_pkg::MCNT_W'(1))
            begin
                mbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            a_reg   <= {{(ACC_W-SXY_W){1'b0}}, a_mag};
            b_reg   <= b_mag;
            neg_reg <= op_a[SXY_W-1] ^ op_b[SX_W-1] ^ mul_sub;
            if (!mul_sub)
            begin
                acc_reg <= '0;
            end
        end
        else if (mbusy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= neg_reg ? acc_reg - a_reg : acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
        if (cmd.store_en)
        begin
            case (cmd.mul_sel)
                lsq_pkg::MUL_SX_SX:  den_reg <= acc_reg;
                lsq_pkg::MUL_SX_SY:  ns_reg  <= acc_reg;
                lsq_pkg::MUL_SX_SXY: ni_reg  <= acc_reg;
                default:             ;
            endcase
        end
    end

    // Restoring divider, one quotient bit per cycle. Only the low 33 bits of
    // the quotient are kept; any one shifted past them marks overflow.
    logic signed [ACC_W-1:0]  num_sel;
    logic        [ACC_W-1:0]  num_mag;
    logic        [ACC_W-1:0]  den_mag;
    logic        [NUM_W-1:0]  nsh_reg;
    logic        [ACC_W-1:0]  d_reg;
    logic        [ACC_W-1:0]  r_reg;
    logic        [OUT_W:0]    q_reg;
    logic                     qovf_reg;
    logic                     dneg_reg;
    lsq_pkg::div_sel_t        dsel_reg;
    logic        [lsq_pkg::DCNT_W-1:0] dcnt_reg;
    logic                     dbusy_reg;
    logic        [ACC_W:0]    r_sh;
    logic                     r_ge;
    logic        [OUT_W:0]    limit;
    logic                     q_sat;
    logic        [OUT_W-1:0]  q_clip;
    logic        [OUT_W-1:0]  q_final;

    assign num_sel = (cmd.div_sel == lsq_pkg::DIV_SLOPE) ? ns_reg : ni_reg;
    assign num_mag = num_sel[ACC_W-1] ? ACC_W'(-num_sel) : num_sel;
    assign den_mag = den_reg[ACC_W-1] ? ACC_W'(-den_reg) : den_reg;

    assign r_sh  = {r_reg, nsh_reg[NUM_W-1]};
    assign r_ge  = r_sh >= {1'b0, d_reg};
    assign limit = dneg_reg ? (OUT_W+1)'(33'h0_8000_0000) : (OUT_W+1)'(33'h0_7FFF_FFFF);
    assign q_sat = qovf_reg || (q_reg > limit);
    assign q_clip  = q_sat ? limit[OUT_W-1:0] : q_reg[OUT_W-1:0];
    assign q_final = dneg_reg ? OUT_W'(-q_clip) : q_clip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= lsq_pkg::DCNT_W'(NUM_W);
        end
        else if (dbusy_reg)
        begin
            if (dcnt_reg == '0)
            begin
                dbusy_reg <= 1'b0;
            end
            else
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            if (cmd.div_sel == lsq_pkg::DIV_SLOPE)
            begin
                nsh_reg <= NUM_W'(num_mag) << lsq_pkg::SLOPE_SHIFT;
            end
            else
            begin
                nsh_reg <= NUM_W'(num_mag) << lsq_pkg::ICPT_SHIFT;
            end
            d_reg    <= den_mag;
            r_reg    <= '0;
            q_reg    <= '0;
            qovf_reg <= 1'b0;
            dneg_reg <= num_sel[ACC_W-1] ^ den_reg[ACC_W-1];
            dsel_reg <= cmd.div_sel;
        end
        else if (dbusy_reg && (dcnt_reg != '0))
        begin
            // The remainder stays below the divisor, so it fits in ACC_W bits.
            r_reg    <= r_ge ? ACC_W'(r_sh - {1'b0, d_reg}) : r_sh[ACC_W-1:0];
            q_reg    <= {q_reg[OUT_W-1:0], r_ge};
            qovf_reg <= qovf_reg | q_reg[OUT_W];
            nsh_reg  <= nsh_reg << 1;
        end
    end

    // Result registers.
    logic signed [OUT_W-1:0] slope_reg;
    logic signed [OUT_W-1:0] icpt_reg;
    logic                    degen_reg;
    logic                    sat_reg;
    logic                    ovf_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fit_begin)
        begin
            slope_reg <= '0;
            icpt_reg  <= '0;
            degen_reg <= (den_reg == '0);
            sat_reg   <= 1'b0;
            ovf_reg   <= drop_reg;
        end
        else if (dbusy_reg && (dcnt_reg == '0))
        begin
            if (dsel_reg == lsq_pkg::DIV_SLOPE)
            begin
                slope_reg <= q_final;
            end
            else
            begin
                icpt_reg <= q_final;
            end
            sat_reg <= sat_reg | q_sat;
        end
    end

    assign status.mul_busy = mbusy_reg;
    assign status.div_busy = dbusy_reg;
    assign status.den_zero = (den_reg == '0);

    assign slope      = slope_reg;
    assign intercept  = icpt_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;
    assign overflowed = ovf_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lsq_controller.sv -----
// Line fit controller: takes samples, then runs the datapath through
// six products and two divisions (none if den_zero). Uses lsq_pkg.
`default_nettype none

module lsq_controller
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             last,
    input  wire logic             out_stall,
    input  wire lsq_pkg::status_t status,
    output logic                  in_stall,
    output logic                  out_valid,
    output lsq_pkg::cmd_t         cmd
);

    lsq_pkg::state_t   state_reg;
    lsq_pkg::state_t   state_next;
    lsq_pkg::mul_sel_t step_reg;
    lsq_pkg::mul_sel_t step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsq_pkg::ST_ACC;
            step_reg  <= lsq_pkg::MUL_N_SXX;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        cmd           = '0;
        cmd.mul_sel   = step_reg;
        cmd.div_sel   = lsq_pkg::DIV_SLOPE;
        case (state_reg)
            lsq_pkg::ST_ACC:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.sample_en = 1'b1;
                    if (last)
                    begin
                        state_next = lsq_pkg::ST_MUL;
                        step_next  = lsq_pkg::MUL_N_SXX;
                    end
                end
            end
            lsq_pkg::ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = lsq_pkg::ST_MUL_WAIT;
            end
            lsq_pkg::ST_MUL_WAIT:
            begin
                if (!status.mul_busy)
                begin
                    // Odd steps close a term of two products.
                    cmd.store_en = step_reg[0];
                    if (step_reg == lsq_pkg::MUL_SX_SXY)
                    begin
                        state_next = lsq_pkg::ST_FIT;
                    end
                    else
                    begin
                        step_next  = lsq_pkg::mul_sel_t'(step_reg + 3'd1);
                        state_next = lsq_pkg::ST_MUL;
                    end
                end
            end
            lsq_pkg::ST_FIT:
            begin
                cmd.fit_begin = 1'b1;
                if (status.den_zero)
                begin
                    state_next = lsq_pkg::ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = lsq_pkg::DIV_SLOPE;
                    state_next    = lsq_pkg::ST_DIV_S;
                end
            end
            lsq_pkg::ST_DIV_S:
            begin
                if (!status.div_busy)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = lsq_pkg::DIV_ICPT;
                    state_next    = lsq_pkg::ST_DIV_I;
                end
            end
            lsq_pkg::ST_DIV_I:
            begin
                if (!status.div_busy)
                begin
                    state_next = lsq_pkg::ST_OUT;
                end
            end
            lsq_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.clear  = 1'b1;
                    state_next = lsq_pkg::ST_ACC;
                end
            end
            default:
            begin
                state_next = lsq_pkg::ST_ACC;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/least_squares_line_fit.sv -----
// Top level of the least-squares line fit: controller plus datapath.
// Depends on lsq_pkg, lsq_controller and lsq_datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  x, y, last
//   result   out        out_valid / out_stall slope, intercept, degenerate,
//                                            saturated, overflowed
//
// Samples stream back to back while the input is not stalled.
// After the sample marked last, six shift-add products and two restoring
// divisions run before the result is offered; a zero denominator skips the
// divisions.
// Input is stalled from the last sample until the result is taken.
// Reset clears all sums and the count; no clearing pass is needed.
`default_nettype none

module least_squares_line_fit
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic signed [lsq_pkg::SAMPLE_WIDTH-1:0] x,
    input  wire logic signed [lsq_pkg::SAMPLE_WIDTH-1:0] y,
    input  wire logic                                    last,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [lsq_pkg::OUT_W-1:0]             slope,
    output logic signed [lsq_pkg::OUT_W-1:0]             intercept,
    output logic                                         degenerate,
    output logic                                         saturated,
    output logic                                         overflowed
);

    lsq_pkg::cmd_t    cmd;
    lsq_pkg::status_t status;

    lsq_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    lsq_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .x          (x),
        .y          (y),
        .cmd        (cmd),
        .status     (status),
        .slope      (slope),
        .intercept  (intercept),
        .degenerate (degenerate),
        .saturated  (saturated),
        .overflowed (overflowed)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lsq_checker.sv -----
// Port-level checks for the line fit, bound to the top level.
// Depends on lsq_pkg and least_squares_line_fit.
`default_nettype none

module lsq_checker
(
    input wire logic                                    clk,
    input wire logic                                    rst_n,
    input wire logic                                    in_valid,
    input wire logic                                    in_stall,
    input wire logic                                    last,
    input wire logic                                    out_valid,
    input wire logic                                    out_stall,
    input wire logic signed [lsq_pkg::OUT_W-1:0]        slope,
    input wire logic signed [lsq_pkg::OUT_W-1:0]        intercept,
    input wire logic                                    degenerate,
    input wire logic                                    saturated
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(slope) && $stable(intercept))
        else $error("result item changed while stalled");

    // A degenerate fit carries zero coefficients and no clipping.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> slope == '0 && intercept == '0 && !saturated)
        else $error("degenerate result with nonzero fields");

    // No sample is taken while a result is pending.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // The last item of a set starts the fit, which blocks further input.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall && !out_valid)
        else $error("fit did not start after last item");

endmodule

bind least_squares_line_fit lsq_checker u_lsq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slope      (slope),
    .intercept  (intercept),
    .degenerate (degenerate),
    .saturated  (saturated)
);

`default_nettype wire
